### design/bgu2x_pkg.sv
// Shared types and constants for the 2x bilinear grid upsampler.
// No dependencies; the config and output interfaces and the upsampler import this package.
package bgu2x_pkg;

	// Fixed field widths
	localparam int CFG_W      = 11;  // grid size registers
	localparam int CFG_ADDR_W = 4;   // register index on the config channel
	localparam int FIDX_W     = 11;  // fine row and column tags

	// Register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_COARSE_COLS = CFG_ADDR_W'(0);
	localparam logic [CFG_ADDR_W-1:0] REG_COARSE_ROWS = CFG_ADDR_W'(1);

	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1024);

	// Which fine point of the current coarse sample is being emitted
	typedef enum logic [1:0] {
		BEAT_COPY,
		BEAT_LEFT,
		BEAT_UP,
		BEAT_CORNER
	} beat_kind_t;

endpackage

### design/bgu2x_if.sv
// Valid/ready channel interfaces for the 2x bilinear grid upsampler.
// Depends on bgu2x_pkg for the fixed field widths.
interface bgu2x_cfg_if import bgu2x_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_ADDR_W-1:0] index;
	logic [CFG_W-1:0]      data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

interface bgu2x_in_if #(parameter int SAMPLE_WIDTH = 32) ();
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] coarse_value;

	modport source (output valid, coarse_value, input ready);
	modport sink   (input valid, coarse_value, output ready);
endinterface

interface bgu2x_out_if import bgu2x_pkg::*; #(parameter int SAMPLE_WIDTH = 32) ();
	logic                           valid;
	logic                           ready;
	logic [FIDX_W-1:0]              fine_row;
	logic [FIDX_W-1:0]              fine_col;
	logic signed [SAMPLE_WIDTH-1:0] fine_value;
	logic                           last_of_run;
	logic                           frame_done;

	modport source (output valid, fine_row, fine_col, fine_value, last_of_run, frame_done,
		input ready);
	modport sink   (input valid, fine_row, fine_col, fine_value, last_of_run, frame_done,
		output ready);
endinterface

### design/bgu2x_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
// Read-first: a read and a write at the same address return the old word.
module bgu2x_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	assign rd_data = rd_data_q;

endmodule

### design/bilinear_grid_upsample_2x.sv
// 2x bilinear prolongation of a row-major coarse grid, one fine point per output beat.
// A coarse beat reaches its first fine beat through stage 1, then the output register.
// Each sample yields 1 to 4 fine points (4 inside the grid), emitted through the single
// output register, which takes one beat per cycle unless the fine channel stalls it.
// Reset: grid size registers return to 1024, position and neighbors clear to zero;
// the line buffer is not cleared and needs no clearing pass.
module bilinear_grid_upsample_2x import bgu2x_pkg::*; #(
	parameter int MAX_COARSE_COLS = 1024,
	parameter int MAX_COARSE_ROWS = 1024,
	parameter int SAMPLE_WIDTH    = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	bgu2x_cfg_if.sink   cfg,
	bgu2x_in_if.sink    coarse,
	bgu2x_out_if.source fine
);

	// Column/row index widths and count widths (count can hold the maximum itself)
	localparam int CIDX_W = $clog2(MAX_COARSE_COLS);
	localparam int CCNT_W = $clog2(MAX_COARSE_COLS + 1);
	localparam int RIDX_W = $clog2(MAX_COARSE_ROWS);
	localparam int RCNT_W = $clog2(MAX_COARSE_ROWS + 1);
	localparam int SUM_W  = SAMPLE_WIDTH + 2;

	// ------------------------------------------------------------------
	// Configuration registers. Any write restarts the grid.
	// ------------------------------------------------------------------
	logic [CFG_W-1:0] cols_cfg_q;
	logic [CFG_W-1:0] rows_cfg_q;
	logic             cfg_wr;

	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_cfg_q <= CFG_RESET;
			rows_cfg_q <= CFG_RESET;
		end else if (cfg_wr) begin
			case (cfg.index)
				REG_COARSE_COLS: cols_cfg_q <= cfg.data;
				REG_COARSE_ROWS: rows_cfg_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Clamp the programmed sizes to 1..MAX; a size of one never has a neighbor.
	logic [CCNT_W-1:0] eff_cols;
	logic [RCNT_W-1:0] eff_rows;

	always_comb begin
		if (cols_cfg_q == '0) begin
			eff_cols = CCNT_W'(1);
		end else if (32'(cols_cfg_q) > 32'(MAX_COARSE_COLS)) begin
			eff_cols = CCNT_W'(MAX_COARSE_COLS);
		end else begin
			eff_cols = CCNT_W'(cols_cfg_q);
		end
		if (rows_cfg_q == '0) begin
			eff_rows = RCNT_W'(1);
		end else if (32'(rows_cfg_q) > 32'(MAX_COARSE_ROWS)) begin
			eff_rows = RCNT_W'(MAX_COARSE_ROWS);
		end else begin
			eff_rows = RCNT_W'(rows_cfg_q);
		end
	end

	// ------------------------------------------------------------------
	// Grid position of the next coarse sample
	// ------------------------------------------------------------------
	logic [CIDX_W-1:0] col_q;
	logic [RIDX_W-1:0] row_q;
	logic              in_beat;
	logic              row_end;
	logic              grid_end;
	logic              frame_end_d;

	assign row_end     = (CCNT_W'(col_q) + CCNT_W'(1)) == eff_cols;
	assign grid_end    = (RCNT_W'(row_q) + RCNT_W'(1)) == eff_rows;
	assign frame_end_d = row_end && grid_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_wr) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_beat) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= grid_end ? '0 : row_q + RIDX_W'(1);
			end else begin
				col_q <= col_q + CIDX_W'(1);
			end
		end
	end

	// ------------------------------------------------------------------
	// Line buffer: read the sample above and overwrite it with the new one
	// in the same cycle; read-first returns the previous row's word.
	// ------------------------------------------------------------------
	logic [SAMPLE_WIDTH-1:0] above_rd;

	bgu2x_ram #(
		.WIDTH (SAMPLE_WIDTH),
		.DEPTH (MAX_COARSE_COLS)
	) u_line_buf (
		.clk     (clk),
		.wr_en   (in_beat),
		.wr_addr (col_q),
		.wr_data (coarse.coarse_value),
		.rd_en   (in_beat),
		.rd_addr (col_q),
		.rd_data (above_rd)
	);

	// ------------------------------------------------------------------
	// Stage 1: the sample being expanded, one fine point per output beat
	// ------------------------------------------------------------------
	logic                           valid_s1;
	logic signed [SAMPLE_WIDTH-1:0] cur_s1;
	logic [CIDX_W-1:0]              col_s1;
	logic [RIDX_W-1:0]              row_s1;
	logic                           has_left_s1;
	logic                           has_up_s1;
	logic                           frame_end_s1;
	beat_kind_t                     kind_q;
	beat_kind_t                     kind_d;
	logic                           last_beat;

	// Neighbors: left and upper-left from the previous sample of the same row, up from the line buffer
	logic signed [SAMPLE_WIDTH-1:0] left_q;
	logic signed [SAMPLE_WIDTH-1:0] upper_left_q;
	logic signed [SAMPLE_WIDTH-1:0] up_val;

	// Output register
	logic                           fine_valid_q;
	logic [FIDX_W-1:0]              fine_row_q;
	logic [FIDX_W-1:0]              fine_col_q;
	logic signed [SAMPLE_WIDTH-1:0] fine_value_q;
	logic                           last_q;
	logic                           done_q;

	logic load_out;
	logic s1_done;

	// Advance a beat when the output register is free or draining this cycle.
	assign load_out     = valid_s1 && (!fine_valid_q || fine.ready);
	assign s1_done      = load_out && last_beat;
	assign coarse.ready = !valid_s1 || s1_done;
	assign in_beat      = coarse.valid && coarse.ready;

	// Top row: no sample above, treat it as zero.
	assign up_val = has_up_s1 ? above_rd : '0;

	always_ff @(posedge clk) begin
		if (in_beat) begin
			cur_s1       <= coarse.coarse_value;
			col_s1       <= col_q;
			row_s1       <= row_q;
			has_left_s1  <= col_q != '0;
			has_up_s1    <= row_q != '0;
			frame_end_s1 <= frame_end_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			kind_q   <= BEAT_COPY;
		end else if (in_beat) begin
			valid_s1 <= 1'b1;
			kind_q   <= BEAT_COPY;
		end else if (s1_done) begin
			valid_s1 <= 1'b0;
		end else if (load_out) begin
			kind_q <= kind_d;
		end
	end

	// Shift the neighbor window once the sample's last beat leaves stage 1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q       <= '0;
			upper_left_q <= '0;
		end else if (cfg_wr) begin
			left_q       <= '0;
			upper_left_q <= '0;
		end else if (s1_done) begin
			left_q       <= cur_s1;
			upper_left_q <= up_val;
		end
	end

	// Next beat: copy, then left half-sum, upper half-sum, corner quarter-sum,
	// skipping the ones whose neighbors do not exist.
	always_comb begin
		kind_d    = kind_q;
		last_beat = 1'b0;
		case (kind_q)
			BEAT_COPY: begin
				if (has_left_s1) begin
					kind_d = BEAT_LEFT;
				end else if (has_up_s1) begin
					kind_d = BEAT_UP;
				end else begin
					last_beat = 1'b1;
				end
			end
			BEAT_LEFT: begin
				if (has_up_s1) begin
					kind_d = BEAT_UP;
				end else begin
					last_beat = 1'b1;
				end
			end
			BEAT_UP: begin
				if (has_left_s1) begin
					kind_d = BEAT_CORNER;
				end else begin
					last_beat = 1'b1;
				end
			end
			BEAT_CORNER: last_beat = 1'b1;
			default:     last_beat = 1'b1;
		endcase
	end

	// Fine point of the current beat. Sums are taken two bits wider and shifted
	// arithmetically, so the halving and quartering round toward minus infinity.
	logic signed [SUM_W-1:0]        sum_left;
	logic signed [SUM_W-1:0]        sum_up;
	logic signed [SUM_W-1:0]        sum_corner;
	logic [FIDX_W-1:0]              row_even;
	logic [FIDX_W-1:0]              col_even;
	logic [FIDX_W-1:0]              beat_row;
	logic [FIDX_W-1:0]              beat_col;
	logic signed [SAMPLE_WIDTH-1:0] beat_value;

	assign sum_left   = SUM_W'(left_q) + SUM_W'(cur_s1);
	assign sum_up     = SUM_W'(up_val) + SUM_W'(cur_s1);
	assign sum_corner = SUM_W'(upper_left_q) + SUM_W'(up_val) + SUM_W'(left_q)
		+ SUM_W'(cur_s1);
	assign row_even   = FIDX_W'({row_s1, 1'b0});
	assign col_even   = FIDX_W'({col_s1, 1'b0});

	always_comb begin
		beat_row   = row_even;
		beat_col   = col_even;
		beat_value = cur_s1;
		case (kind_q)
			BEAT_COPY: begin
				beat_value = cur_s1;
			end
			BEAT_LEFT: begin
				beat_col   = col_even - FIDX_W'(1);
				beat_value = SAMPLE_WIDTH'(sum_left >>> 1);
			end
			BEAT_UP: begin
				beat_row   = row_even - FIDX_W'(1);
				beat_value = SAMPLE_WIDTH'(sum_up >>> 1);
			end
			BEAT_CORNER: begin
				beat_row   = row_even - FIDX_W'(1);
				beat_col   = col_even - FIDX_W'(1);
				beat_value = SAMPLE_WIDTH'(sum_corner >>> 2);
			end
			default: begin
				beat_value = cur_s1;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Output register: hold while stalled, empty when no beat is waiting, load the next beat otherwise
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fine_valid_q <= 1'b0;
		end else if (load_out) begin
			fine_valid_q <= 1'b1;
		end else if (fine.ready) begin
			fine_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			fine_row_q   <= beat_row;
			fine_col_q   <= beat_col;
			fine_value_q <= beat_value;
			last_q       <= last_beat;
			done_q       <= last_beat && frame_end_s1;
		end
	end

	assign fine.valid       = fine_valid_q;
	assign fine.fine_row    = fine_row_q;
	assign fine.fine_col    = fine_col_q;
	assign fine.fine_value  = fine_value_q;
	assign fine.last_of_run = last_q;
	assign fine.frame_done  = done_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_done_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(fine_valid_q && done_q) |-> last_q)
		else $error("frame_done beat is not the last of its sample");

	a_new_sample_copy: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> (valid_s1 && kind_q == BEAT_COPY))
		else $error("new sample did not start with its copy beat");

	a_grid_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(in_beat && frame_end_d && !cfg_wr) |=> (col_q == '0 && row_q == '0))
		else $error("grid position did not wrap after the last sample");

endmodule
